// File: sv/bloch_spinlock_euler_step_top_defines.svh
// Assertion macros for the spin-lock Euler step block.
// Included by sv/bloch_spinlock_euler_step_top.sv; no other dependencies.
`ifndef BLOCH_SPINLOCK_EULER_STEP_TOP_DEFINES_SVH
`define BLOCH_SPINLOCK_EULER_STEP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bse: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bse: next-cycle check failed");

`endif

// File: sv/bse_pkg.sv
// Shared types, constants and the rate-matrix lookup for the Euler step block.
// No dependencies; used by sv/bloch_spinlock_euler_step_top.sv.
package bse_pkg;

  // Field widths and fixed-point formats.
  localparam int MAG_W      = 32;  // signed Q2.30 magnetization
  localparam int RATE_W     = 32;  // signed Q20.12 rates
  localparam int DT_W       = 32;  // unsigned Q0.32 time step
  localparam int RATE_FRAC  = 12;
  localparam int NUM_AXES   = 3;
  localparam int AXIS_W     = 2;

  // Datapath widths: one row sum of three floored products, the shared
  // multiplier operands and product, and the final update sum.
  localparam int TERM_W     = RATE_W + MAG_W - RATE_FRAC;
  localparam int ACC_W      = TERM_W + 2;
  localparam int ACC_HI_W   = ACC_W - DT_W;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int SUM_W      = ACC_HI_W + DT_W + 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [MAG_W-1:0] MAG_ONE = MAG_W'(1) << (MAG_W - 2);
  localparam logic [MAG_W-1:0] MAG_MAX = {1'b0, {(MAG_W-1){1'b1}}};
  localparam logic [MAG_W-1:0] MAG_MIN = {1'b1, {(MAG_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_R1     = 3'd0,
    CFG_R2     = 3'd1,
    CFG_DT     = 3'd2,
    CFG_INIT_X = 3'd3,
    CFG_INIT_Y = 3'd4,
    CFG_INIT_Z = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_COMMIT,
    ST_EMIT
  } state_e;

  // Slots of one matrix row in the sequencer.
  typedef enum logic [2:0] {
    PH_T0   = 3'd0,
    PH_T1   = 3'd1,
    PH_T2   = 3'd2,
    PH_WAIT = 3'd3,
    PH_LO   = 3'd4,
    PH_HI   = 3'd5
  } phase_e;

  // What the registered product is used for.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_TERM_FIRST,
    OP_TERM,
    OP_DT_LO,
    OP_DT_HI
  } op_e;

  typedef enum logic [2:0] {
    RS_R1,
    RS_R2,
    RS_WX,
    RS_WY,
    RS_DW
  } rate_sel_e;

  typedef struct packed {
    rate_sel_e sel;
    logic      neg;
  } term_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] drive_x;
    logic signed [RATE_W-1:0] drive_y;
    logic signed [RATE_W-1:0] offresonance;
    logic                     first;
    logic                     last;
  } in_word_t;

  typedef struct packed {
    logic signed [MAG_W-1:0] final_mag_x;
    logic signed [MAG_W-1:0] final_mag_y;
    logic signed [MAG_W-1:0] final_mag_z;
  } out_word_t;

  // Entry of the rate matrix for a row and a magnetization component:
  // which rate it uses and whether the product is subtracted.
  function automatic term_t term_info(logic [AXIS_W-1:0] row, logic [AXIS_W-1:0] k);
    term_t t;
    t = '{sel: RS_R1, neg: 1'b0};
    unique case ({row, k})
      {2'd0, 2'd0}: t = '{sel: RS_R1, neg: 1'b1};
      {2'd0, 2'd1}: t = '{sel: RS_DW, neg: 1'b0};
      {2'd0, 2'd2}: t = '{sel: RS_WY, neg: 1'b1};
      {2'd1, 2'd0}: t = '{sel: RS_DW, neg: 1'b1};
      {2'd1, 2'd1}: t = '{sel: RS_R2, neg: 1'b1};
      {2'd1, 2'd2}: t = '{sel: RS_WX, neg: 1'b0};
      {2'd2, 2'd0}: t = '{sel: RS_WY, neg: 1'b0};
      {2'd2, 2'd1}: t = '{sel: RS_WX, neg: 1'b1};
      {2'd2, 2'd2}: t = '{sel: RS_R2, neg: 1'b1};
      default:      t = '{sel: RS_R1, neg: 1'b0};
    endcase
    return t;
  endfunction

endpackage

// File: sv/bloch_spinlock_euler_step_top.sv
// Spin-lock Bloch forward-Euler step: sequencer, shared multiplier and state.
// Depends on sv/bse_pkg.sv and sv/bloch_spinlock_euler_step_top_defines.svh.
//
//   channel   direction  handshake               payload
//   in        sink       in_valid_i/in_stall_o   bse_pkg::in_word_t
//   out       source     out_valid_o/out_stall_i bse_pkg::out_word_t
//   cfg       sink       cfg_we_i                cfg_idx_i, cfg_data_i
//
// Each input word runs through three rows of six slots on one shared 33x33
// multiplier, plus drain and commit, and an emit state when last is set.
// Reset clears the configuration registers (initial z = 1.0) and the state.
// A finished result waits in the output register while the next word runs;
// if it is still stalled when the next result is ready, that word waits.
`include "bloch_spinlock_euler_step_top_defines.svh"

module bloch_spinlock_euler_step_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  bse_pkg::in_word_t                    in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output bse_pkg::out_word_t                   out_word_o,
  input  logic                                 cfg_we_i,
  input  logic [bse_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [bse_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  // Configuration registers.
  logic signed [bse_pkg::RATE_W-1:0] r1_q, r2_q;
  logic        [bse_pkg::DT_W-1:0]   dt_q;
  logic signed [bse_pkg::MAG_W-1:0]  init_q [bse_pkg::NUM_AXES];

  // Sample and state.
  logic signed [bse_pkg::RATE_W-1:0] wx_q, wy_q, dw_q;
  logic                              last_q;
  logic signed [bse_pkg::MAG_W-1:0]  mag_q [bse_pkg::NUM_AXES];
  logic signed [bse_pkg::MAG_W-1:0]  new_q [bse_pkg::NUM_AXES];

  // Sequencer.
  bse_pkg::state_e            state_q, state_d;
  bse_pkg::phase_e            ph_q, ph_d;
  logic [bse_pkg::AXIS_W-1:0] row_q, row_d;
  bse_pkg::op_e               issue_op;
  logic                       accept;
  logic                       out_load;

  // Multiplier pipeline register and row accumulator.
  bse_pkg::op_e                       op_q;
  logic [bse_pkg::AXIS_W-1:0]         tag_row_q;
  logic                               tag_neg_q;
  logic signed [bse_pkg::PROD_W-1:0]  prod_q, prod_d;
  logic signed [bse_pkg::ACC_W-1:0]   acc_q, acc_d, acc_base, term_ext;
  logic signed [bse_pkg::TERM_W-1:0]  term_val;
  logic        [bse_pkg::DT_W-1:0]    lo_q;

  logic                               out_valid_q;
  bse_pkg::out_word_t                 out_q;

  // Operand selection.
  bse_pkg::term_t                     tinfo;
  logic [bse_pkg::AXIS_W-1:0]         mag_k;
  logic signed [bse_pkg::RATE_W-1:0]  rate_op;
  logic signed [bse_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [bse_pkg::ACC_HI_W-1:0] acc_hi;

  // Update sum and saturation.
  logic signed [bse_pkg::SUM_W-1:0]   upd_sum;
  logic                               upd_fits;
  logic [bse_pkg::MAG_W-1:0]          upd_sat;

  assign in_stall_o  = (state_q != bse_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_q      <= '0;
      r2_q      <= '0;
      dt_q      <= '0;
      init_q[0] <= '0;
      init_q[1] <= '0;
      init_q[2] <= bse_pkg::MAG_ONE;
    end else if (cfg_we_i) begin
      unique case (bse_pkg::cfg_idx_e'(cfg_idx_i))
        bse_pkg::CFG_R1:     r1_q      <= cfg_data_i[bse_pkg::RATE_W-1:0];
        bse_pkg::CFG_R2:     r2_q      <= cfg_data_i[bse_pkg::RATE_W-1:0];
        bse_pkg::CFG_DT:     dt_q      <= cfg_data_i[bse_pkg::DT_W-1:0];
        bse_pkg::CFG_INIT_X: init_q[0] <= cfg_data_i[bse_pkg::MAG_W-1:0];
        bse_pkg::CFG_INIT_Y: init_q[1] <= cfg_data_i[bse_pkg::MAG_W-1:0];
        bse_pkg::CFG_INIT_Z: init_q[2] <= cfg_data_i[bse_pkg::MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // State register of the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bse_pkg::ST_IDLE;
      ph_q    <= bse_pkg::PH_T0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      row_q   <= row_d;
    end
  end

  // Next state and issue slot: per row three products, a bubble for the
  // last accumulation, then the two halves of the time-step product.
  always_comb begin
    state_d  = state_q;
    ph_d     = ph_q;
    row_d    = row_q;
    issue_op = bse_pkg::OP_NONE;
    out_load = 1'b0;
    unique case (state_q)
      bse_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = bse_pkg::ST_RUN;
          ph_d    = bse_pkg::PH_T0;
          row_d   = '0;
        end
      end
      bse_pkg::ST_RUN: begin
        unique case (ph_q)
          bse_pkg::PH_T0:   issue_op = bse_pkg::OP_TERM_FIRST;
          bse_pkg::PH_T1,
          bse_pkg::PH_T2:   issue_op = bse_pkg::OP_TERM;
          bse_pkg::PH_LO:   issue_op = bse_pkg::OP_DT_LO;
          bse_pkg::PH_HI:   issue_op = bse_pkg::OP_DT_HI;
          default:          issue_op = bse_pkg::OP_NONE;
        endcase
        if (ph_q == bse_pkg::PH_HI) begin
          ph_d = bse_pkg::PH_T0;
          if (row_q == bse_pkg::AXIS_W'(bse_pkg::NUM_AXES - 1)) begin
            state_d = bse_pkg::ST_DRAIN;
          end else begin
            row_d = row_q + 2'd1;
          end
        end else begin
          ph_d = bse_pkg::phase_e'(ph_q + 3'd1);
        end
      end
      bse_pkg::ST_DRAIN: state_d = bse_pkg::ST_COMMIT;
      bse_pkg::ST_COMMIT: state_d = last_q ? bse_pkg::ST_EMIT : bse_pkg::ST_IDLE;
      bse_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = bse_pkg::ST_IDLE;
        end
      end
      default: state_d = bse_pkg::ST_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mag_k = ((issue_op == bse_pkg::OP_TERM_FIRST) || (issue_op == bse_pkg::OP_TERM))
            ? ph_q[bse_pkg::AXIS_W-1:0] : '0;
    tinfo = bse_pkg::term_info(row_q, mag_k);
    unique case (tinfo.sel)
      bse_pkg::RS_R1: rate_op = r1_q;
      bse_pkg::RS_R2: rate_op = r2_q;
      bse_pkg::RS_WX: rate_op = wx_q;
      bse_pkg::RS_WY: rate_op = wy_q;
      bse_pkg::RS_DW: rate_op = dw_q;
      default:        rate_op = '0;
    endcase
    acc_hi = acc_q[bse_pkg::ACC_W-1:bse_pkg::DT_W];
    unique case (issue_op)
      bse_pkg::OP_TERM_FIRST,
      bse_pkg::OP_TERM: begin
        mul_a = bse_pkg::MUL_W'(rate_op);
        mul_b = bse_pkg::MUL_W'(mag_q[mag_k]);
      end
      bse_pkg::OP_DT_LO: begin
        mul_a = bse_pkg::MUL_W'(dt_q);
        mul_b = bse_pkg::MUL_W'(acc_q[bse_pkg::DT_W-1:0]);
      end
      bse_pkg::OP_DT_HI: begin
        mul_a = bse_pkg::MUL_W'(dt_q);
        mul_b = bse_pkg::MUL_W'(acc_hi);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Multiplier output register with the tag of what it feeds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= bse_pkg::OP_NONE;
    end else begin
      op_q <= issue_op;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    tag_row_q <= row_q;
    tag_neg_q <= tinfo.neg;
  end

  // Row accumulation of floored products, and the saturated Euler update.
  // The time-step product is split at bit 32: floor of the whole equals
  // the high partial product plus the upper word of the low one.
  always_comb begin
    term_val = prod_q[bse_pkg::RATE_W+bse_pkg::MAG_W-1:bse_pkg::RATE_FRAC];
    term_ext = bse_pkg::ACC_W'(term_val);
    acc_base = (op_q == bse_pkg::OP_TERM_FIRST) ? '0 : acc_q;
    acc_d    = tag_neg_q ? (acc_base - term_ext) : (acc_base + term_ext);
    upd_sum  = bse_pkg::SUM_W'(prod_q) + bse_pkg::SUM_W'(lo_q)
             + bse_pkg::SUM_W'(mag_q[tag_row_q]);
    upd_fits = (upd_sum[bse_pkg::SUM_W-1:bse_pkg::MAG_W-1] == '0) ||
               (upd_sum[bse_pkg::SUM_W-1:bse_pkg::MAG_W-1] == '1);
    if (upd_fits) begin
      upd_sat = upd_sum[bse_pkg::MAG_W-1:0];
    end else begin
      upd_sat = upd_sum[bse_pkg::SUM_W-1] ? bse_pkg::MAG_MIN : bse_pkg::MAG_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((op_q == bse_pkg::OP_TERM_FIRST) || (op_q == bse_pkg::OP_TERM)) begin
      acc_q <= acc_d;
    end
    if (op_q == bse_pkg::OP_DT_LO) begin
      lo_q <= prod_q[2*bse_pkg::DT_W-1:bse_pkg::DT_W];
    end
    if (op_q == bse_pkg::OP_DT_HI) begin
      new_q[tag_row_q] <= upd_sat;
    end
    if (accept) begin
      wx_q   <= in_word_i.drive_x;
      wy_q   <= in_word_i.drive_y;
      dw_q   <= in_word_i.offresonance;
      last_q <= in_word_i.last;
    end
  end

  // Magnetization: reload on a first word, commit after all three rows.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q[0] <= '0;
      mag_q[1] <= '0;
      mag_q[2] <= '0;
    end else if (accept && in_word_i.first) begin
      mag_q[0] <= init_q[0];
      mag_q[1] <= init_q[1];
      mag_q[2] <= init_q[2];
    end else if (state_q == bse_pkg::ST_COMMIT) begin
      mag_q[0] <= new_q[0];
      mag_q[1] <= new_q[1];
      mag_q[2] <= new_q[2];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= '{final_mag_x: mag_q[0], final_mag_y: mag_q[1], final_mag_z: mag_q[2]};
    end
  end

  // A reload takes the initial values present at acceptance.
  `BSE_ASSERT_NEXT(a_reload_init, clk_i, rst_ni, accept && in_word_i.first,
                   (mag_q[0] == $past(init_q[0])) && (mag_q[1] == $past(init_q[1])) &&
                   (mag_q[2] == $past(init_q[2])))
  // The high half of the time-step product always follows the low half.
  `BSE_ASSERT_NOW(a_hi_after_lo, clk_i, rst_ni, op_q == bse_pkg::OP_DT_HI,
                  $past(op_q) == bse_pkg::OP_DT_LO)
  // Only a word marked last leads to a result.
  `BSE_ASSERT_NOW(a_emit_last, clk_i, rst_ni, state_q == bse_pkg::ST_EMIT, last_q)
  // A new result appears only after the emit state loaded it.
  `BSE_ASSERT_NOW(a_out_from_emit, clk_i, rst_ni, $rose(out_valid_q),
                  $past(state_q) == bse_pkg::ST_EMIT)

endmodule

// File: sim/tb_bloch_spinlock_euler_step_top.sv
// Self-checking testbench for the spin-lock Bloch forward-Euler step block.
// Depends on sv/bse_pkg.sv and the top level sv/bloch_spinlock_euler_step_top.sv.
// An internal fixed-point predictor supplies the expected final magnetization of each packet.
module tb_bloch_spinlock_euler_step_top;
  import bse_pkg::*;

  localparam int     HALF_PERIOD    = 4;
  localparam int     RESET_CYCLES   = 6;
  localparam int     IDLE_PCT       = 38;
  localparam int     SETTLE_CYCLES  = 32;
  localparam int     QUIET_LIMIT    = 2000;
  localparam int     NUM_PHASES     = 8;
  localparam int     PHASE_WORDS    = 222;
  localparam int     STEADY_PHASE   = 3;
  localparam int     STEP_FRAC      = DT_W;
  localparam int     RATE_SPAN      = 1 << 20;
  localparam longint PRODUCT_LIMIT  = 64'sd1 <<< 61;
  localparam longint SPIN_HI        = (64'sd1 <<< (MAG_W - 1)) - 1;
  localparam longint SPIN_LO        = -SPIN_HI - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE_HI = 3'd7;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_word_t              in_word_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_word_t             out_word_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Words waiting to be sent and final magnetizations waiting to come out.
  in_word_t  pending_words[$];
  out_word_t final_mag_due[$];

  bit word_taken = 1'b0;
  bit steady     = 1'b0;
  int words_sent     = 0;
  int results_seen   = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int settings_used  = 0;

  // Predictor copy of the registers and the magnetization.
  longint r1_rate, r2_rate, dt_step, init_x, init_y, init_z;
  longint spin_x, spin_y, spin_z;

  bloch_spinlock_euler_step_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Floor of a*b / 2^shift, clamped to plus or minus 2^61.
  function automatic longint fixed_mul_floor(longint a, longint b, int shift);
    logic signed [127:0] wa, wb, q;
    wa = a;
    wb = b;
    q  = (wa * wb) >>> shift;
    if (q > PRODUCT_LIMIT) return PRODUCT_LIMIT;
    if (q < -PRODUCT_LIMIT) return -PRODUCT_LIMIT;
    return longint'(q);
  endfunction

  // Old component plus time step times derivative, saturated to the magnetization range.
  function automatic longint saturating_update(longint m, longint deriv);
    longint s;
    s = m + fixed_mul_floor(dt_step, deriv, STEP_FRAC);
    if (s > SPIN_HI) return SPIN_HI;
    if (s < SPIN_LO) return SPIN_LO;
    return s;
  endfunction

  // One Euler step on the predictor state; returns 1 when the word closes a packet.
  function automatic bit advance_spin(in_word_t w, output out_word_t res);
    longint wx, wy, dw, dx, dy, dz, nx, ny, nz;
    wx = w.drive_x;
    wy = w.drive_y;
    dw = w.offresonance;
    if (w.first) begin
      spin_x = init_x;
      spin_y = init_y;
      spin_z = init_z;
    end
    // All three rows use the magnetization from before the step.
    dx = -fixed_mul_floor(r1_rate, spin_x, RATE_FRAC) + fixed_mul_floor(dw, spin_y, RATE_FRAC)
         - fixed_mul_floor(wy, spin_z, RATE_FRAC);
    dy = -fixed_mul_floor(dw, spin_x, RATE_FRAC) - fixed_mul_floor(r2_rate, spin_y, RATE_FRAC)
         + fixed_mul_floor(wx, spin_z, RATE_FRAC);
    dz = fixed_mul_floor(wy, spin_x, RATE_FRAC) - fixed_mul_floor(wx, spin_y, RATE_FRAC)
         - fixed_mul_floor(r2_rate, spin_z, RATE_FRAC);
    nx = saturating_update(spin_x, dx);
    ny = saturating_update(spin_y, dy);
    nz = saturating_update(spin_z, dz);
    spin_x = nx;
    spin_y = ny;
    spin_z = nz;
    res.final_mag_x = nx[MAG_W-1:0];
    res.final_mag_y = ny[MAG_W-1:0];
    res.final_mag_z = nz[MAG_W-1:0];
    return w.last;
  endfunction

  // Register write as seen by the predictor; unmapped indexes are dropped.
  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    int sdata;
    sdata = data;
    case (idx)
      CFG_R1:     r1_rate = sdata;
      CFG_R2:     r2_rate = sdata;
      CFG_DT:     dt_step = longint'({32'b0, data});
      CFG_INIT_X: init_x = sdata;
      CFG_INIT_Y: init_y = sdata;
      CFG_INIT_Z: init_z = sdata;
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR at %0t: %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Rates are mostly moderate, sometimes full range or an extreme.
  function automatic logic [31:0] pick_rate();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = $urandom();
      1:       v = ($urandom_range(0, 1) == 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: v = int'($urandom_range(0, 2 * RATE_SPAN)) - RATE_SPAN;
    endcase
    return v;
  endfunction

  task automatic push_word(logic [31:0] wx, logic [31:0] wy, logic [31:0] dw, bit f, bit l);
    in_word_t w;
    w = '{drive_x: wx, drive_y: wy, offresonance: dw, first: f, last: l};
    pending_words.push_back(w);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    apply_reg_write(idx, data);
  endtask

  task automatic write_setting(logic [31:0] r1, logic [31:0] r2, logic [31:0] dt,
                               logic [31:0] ix, logic [31:0] iy, logic [31:0] iz);
    write_reg(CFG_R1, r1);
    write_reg(CFG_R2, r2);
    write_reg(CFG_DT, dt);
    write_reg(CFG_INIT_X, ix);
    write_reg(CFG_INIT_Y, iy);
    write_reg(CFG_INIT_Z, iz);
    // Writes to unmapped indexes must leave every register alone.
    write_reg(CFG_NONE_LO, $urandom());
    write_reg(CFG_NONE_HI, $urandom());
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Block is idle once all words are in, all results out, and the last step has finished.
  task automatic wait_for_idle();
    do @(posedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || final_mag_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Driver: a new word goes out at the falling edge once the previous one was taken.
  always @(negedge clk_i) begin
    if (!in_valid_i || word_taken) begin
      if (pending_words.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid_i <= 1'b1;
        in_word_i  <= pending_words.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Monitor: predicts on each accepted input word, checks each accepted result word.
  always @(posedge clk_i) begin : monitor
    out_word_t want;
    bit        in_hs, out_hs;
    in_hs  = rst_ni && in_valid_i && !in_stall_o;
    out_hs = rst_ni && out_valid_o && !out_stall_i;
    word_taken <= in_hs;
    if (in_hs) begin
      words_sent++;
      if (advance_spin(in_word_i, want)) final_mag_due.push_back(want);
    end
    if (out_hs) begin
      results_seen++;
      if (final_mag_due.size() == 0) begin
        report_mismatch("result with nothing expected, x", out_word_o.final_mag_x, '0);
      end else begin
        want = final_mag_due.pop_front();
        if (out_word_o.final_mag_x !== want.final_mag_x)
          report_mismatch("final_mag_x", out_word_o.final_mag_x, want.final_mag_x);
        if (out_word_o.final_mag_y !== want.final_mag_y)
          report_mismatch("final_mag_y", out_word_o.final_mag_y, want.final_mag_y);
        if (out_word_o.final_mag_z !== want.final_mag_z)
          report_mismatch("final_mag_z", out_word_o.final_mag_z, want.final_mag_z);
      end
    end
    // Watchdog on handshake activity.
    if (rst_ni) begin
      if (in_hs || out_hs) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int          sent;
    int          len;
    bit          well_formed;
    logic [31:0] r1, r2, dt, ix, iy, iz;

    // Predictor registers start at their reset values.
    r1_rate = 0;
    r2_rate = 0;
    dt_step = 0;
    init_x  = 0;
    init_y  = 0;
    init_z  = longint'(MAG_ONE);
    spin_x  = 0;
    spin_y  = 0;
    spin_z  = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: a step with no reload keeps the cleared state; a zero time step
    // emits the initial values unchanged.
    push_word(32'h0006_4000, 32'h0003_2000, 32'h0001_0000, 1'b0, 1'b1);
    push_word(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b1);
    wait_for_idle();

    // Moderate relaxation, about a millisecond per step, starting along z.
    write_setting(32'h0000_2000, 32'h0000_a000, 32'h0041_8937, 32'h0, 32'h0, MAG_ONE);
    push_word(32'h0006_4000, 32'h0, 32'h0, 1'b1, 1'b0);
    push_word(32'h0, 32'h0006_4000, 32'h0, 1'b0, 1'b0);
    push_word(32'h0, 32'h0, 32'h0006_4000, 1'b0, 1'b1);
    push_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b1);
    push_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
    push_word(32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b1, 1'b1);
    push_word(32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
    push_word(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b1, 1'b1);
    push_word(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 1'b1, 1'b1);
    push_word(32'hffff_ffff, 32'h0000_0001, 32'hffff_f000, 1'b0, 1'b0);
    push_word(32'h0000_1000, 32'hffff_ffff, 32'h0000_0001, 1'b0, 1'b1);
    wait_for_idle();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 0) begin
        r1 = 32'h7fff_ffff; r2 = 32'h7fff_ffff; dt = 32'hffff_ffff;
        ix = 32'h7fff_ffff; iy = 32'h7fff_ffff; iz = 32'h7fff_ffff;
      end else if (phase == 1) begin
        r1 = 32'h8000_0000; r2 = 32'h8000_0000; dt = 32'h0;
        ix = 32'h8000_0000; iy = 32'h8000_0000; iz = 32'h8000_0000;
      end else begin
        r1 = pick_rate();
        r2 = pick_rate();
        dt = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1 << 16, 1 << 24);
        ix = $urandom();
        iy = $urandom();
        iz = ($urandom_range(0, 1) == 1) ? MAG_ONE : $urandom();
      end
      write_setting(r1, r2, dt, ix, iy, iz);
      steady = (phase == STEADY_PHASE);

      // Mostly well-formed packets; the rest carry random first and last flags.
      sent = 0;
      while (sent < PHASE_WORDS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        well_formed = ($urandom_range(0, 4) != 0);
        for (int k = 0; k < len; k++) begin
          if (well_formed)
            push_word(pick_rate(), pick_rate(), pick_rate(), k == 0, k == len - 1);
          else
            push_word(pick_rate(), pick_rate(), pick_rate(),
                      $urandom_range(0, 1), $urandom_range(0, 1));
        end
        sent += len;
      end
      wait_for_idle();
      steady = 1'b0;
    end

    $display("Summary: %0d input words and %0d result words checked", words_sent, results_seen);
    $display("Summary: %0d register settings, %0d mismatches", settings_used, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
